### rtl/lppd_pkg.sv
// ----------------------------------------------------------------------------
// lppd_pkg
// Shared types and constants for the length-prefixed packet deframer.
// ----------------------------------------------------------------------------
`default_nettype none

package lppd_pkg;

  // Header layout
  localparam int unsigned HeaderBytes  = 40;
  localparam int unsigned SessionBytes = 32;
  localparam int unsigned PosBits      = $clog2(HeaderBytes);

  // Configuration defaults
  localparam logic [31:0] LimitReset = 32'd1024000;
  localparam int unsigned QueueDepth = 4;

  // Register map (word index)
  localparam logic RegBodyLimit = 1'b0;

  // Header byte positions
  localparam logic [PosBits-1:0] PosVerLo   = PosBits'(0);
  localparam logic [PosBits-1:0] PosVerHi   = PosBits'(1);
  localparam logic [PosBits-1:0] PosCmdLo   = PosBits'(2);
  localparam logic [PosBits-1:0] PosCmdHi   = PosBits'(3);
  localparam logic [PosBits-1:0] PosLen0    = PosBits'(4);
  localparam logic [PosBits-1:0] PosLen1    = PosBits'(5);
  localparam logic [PosBits-1:0] PosLen2    = PosBits'(6);
  localparam logic [PosBits-1:0] PosLen3    = PosBits'(7);
  localparam logic [PosBits-1:0] PosHdrLast = PosBits'(HeaderBytes - 1);

  // One classified item travelling from the front to the back
  typedef struct packed {
    logic [7:0]  packet_byte;
    logic        start_of_packet;
    logic        end_of_packet;
    logic [15:0] command_code;
    logic [15:0] protocol_version;
    logic [31:0] body_size;
    logic        framing_error;
  } item_t;

endpackage

`default_nettype wire

### rtl/lppd_front.sv
// ----------------------------------------------------------------------------
// lppd_front
// Accepts stream bytes, tracks the packet position, captures header fields
// and classifies each byte into a queue item.
// ----------------------------------------------------------------------------
`default_nettype none

module lppd_front (
  input  wire                  clk,
  input  wire                  rst,
  input  wire                  s_tvalid,
  output logic                 s_tready,
  input  wire  [7:0]           s_tdata,     // data_byte[7:0]
  input  wire  [31:0]          limit,
  input  wire                  push_ready,
  output logic                 push_valid,
  output lppd_pkg::item_t      push_item
);

  logic [lppd_pkg::PosBits-1:0] hdr_pos;
  logic                         in_body;
  logic [31:0]                  body_left;
  logic [31:0]                  held_length;
  logic [15:0]                  held_command;
  logic [15:0]                  held_version;
  logic                         halted;

  logic accept;
  logic hdr_last;
  logic bad_len;
  logic eop;

  // Drop everything once halted; otherwise wait for queue space
  assign s_tready = halted | push_ready;
  assign accept   = s_tvalid & s_tready;

  // Classify the current byte
  assign hdr_last = !in_body && (hdr_pos == lppd_pkg::PosHdrLast);
  assign bad_len  = hdr_last && (held_length >= limit);
  assign eop      = (hdr_last && (held_length == 32'd0)) ||
                    (in_body && (body_left == 32'd1));

  assign push_valid = accept & !halted;

  // Build the queue item
  always_comb begin
    push_item = '0;
    if (bad_len) begin
      push_item.framing_error = 1'b1;
    end else begin
      push_item.packet_byte     = s_tdata;
      push_item.start_of_packet = !in_body && (hdr_pos == lppd_pkg::PosVerLo);
      push_item.end_of_packet   = eop;
      if (eop) begin
        push_item.command_code     = held_command;
        push_item.protocol_version = held_version;
        push_item.body_size        = held_length;
      end
    end
  end

  // Advance position and capture header fields
  always_ff @(posedge clk) begin
    if (rst) begin
      hdr_pos      <= '0;
      in_body      <= 1'b0;
      body_left    <= '0;
      held_length  <= '0;
      held_command <= '0;
      held_version <= '0;
      halted       <= 1'b0;
    end else if (push_valid) begin
      if (bad_len) begin
        halted <= 1'b1;
      end else if (hdr_last) begin
        if (held_length == 32'd0) begin
          hdr_pos <= '0;
        end else begin
          in_body   <= 1'b1;
          body_left <= held_length;
        end
      end else if (in_body) begin
        body_left <= body_left - 32'd1;
        if (body_left == 32'd1) begin
          in_body <= 1'b0;
          hdr_pos <= '0;
        end
      end else begin
        hdr_pos <= hdr_pos + lppd_pkg::PosBits'(1);
        case (hdr_pos)
          lppd_pkg::PosVerLo: held_version[7:0]   <= s_tdata;
          lppd_pkg::PosVerHi: held_version[15:8]  <= s_tdata;
          lppd_pkg::PosCmdLo: held_command[7:0]   <= s_tdata;
          lppd_pkg::PosCmdHi: held_command[15:8]  <= s_tdata;
          lppd_pkg::PosLen0:  held_length[7:0]    <= s_tdata;
          lppd_pkg::PosLen1:  held_length[15:8]   <= s_tdata;
          lppd_pkg::PosLen2:  held_length[23:16]  <= s_tdata;
          lppd_pkg::PosLen3:  held_length[31:24]  <= s_tdata;
          default: ;
        endcase
      end
    end
  end

endmodule

`default_nettype wire

### rtl/lppd_queue.sv
// ----------------------------------------------------------------------------
// lppd_queue
// Small register queue that decouples the classifier from the output stage.
// ----------------------------------------------------------------------------
`default_nettype none

module lppd_queue #(
  parameter int unsigned Depth = lppd_pkg::QueueDepth
) (
  input  wire                  clk,
  input  wire                  rst,
  input  wire                  push_valid,
  output logic                 push_ready,
  input  lppd_pkg::item_t      push_item,
  output logic                 pop_valid,
  input  wire                  pop_ready,
  output lppd_pkg::item_t      pop_item
);

  localparam int unsigned PtrBits = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int unsigned CntBits = $clog2(Depth + 1);

  lppd_pkg::item_t     slots [Depth];
  logic [PtrBits-1:0]  wr_ptr;
  logic [PtrBits-1:0]  rd_ptr;
  logic [CntBits-1:0]  count;

  logic do_push;
  logic do_pop;

  assign push_ready = (count != CntBits'(Depth));
  assign pop_valid  = (count != '0);
  assign pop_item   = slots[rd_ptr];
  assign do_push    = push_valid & push_ready;
  assign do_pop     = pop_valid & pop_ready;

  // Store pushed items
  always_ff @(posedge clk) begin
    if (do_push) begin
      slots[wr_ptr] <= push_item;
    end
  end

  // Move pointers and occupancy
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr <= (wr_ptr == PtrBits'(Depth - 1)) ? '0 : wr_ptr + PtrBits'(1);
      end
      if (do_pop) begin
        rd_ptr <= (rd_ptr == PtrBits'(Depth - 1)) ? '0 : rd_ptr + PtrBits'(1);
      end
      if (do_push && !do_pop) begin
        count <= count + CntBits'(1);
      end else if (do_pop && !do_push) begin
        count <= count - CntBits'(1);
      end
    end
  end

endmodule

`default_nettype wire

### rtl/lppd_back.sv
// ----------------------------------------------------------------------------
// lppd_back
// Output register stage: pops queue items and presents them on the master
// stream, holding an item until the receiver takes it.
// ----------------------------------------------------------------------------
`default_nettype none

module lppd_back (
  input  wire                  clk,
  input  wire                  rst,
  input  wire                  pop_valid,
  output logic                 pop_ready,
  input  lppd_pkg::item_t      pop_item,
  output logic                 m_tvalid,
  input  wire                  m_tready,
  output logic [71:0]          m_tdata,   // packet_byte[7:0], command_code[23:8],
                                          // protocol_version[39:24], body_size[71:40]
  output logic                 m_tlast,   // end_of_packet
  output logic [1:0]           m_tuser    // start_of_packet[0], framing_error[1]
);

  lppd_pkg::item_t out_item;

  // Load when the output register is empty or being drained
  assign pop_ready = !m_tvalid || m_tready;

  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (pop_ready) begin
      m_tvalid <= pop_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (pop_ready && pop_valid) begin
      out_item <= pop_item;
    end
  end

  // Pack the item onto the stream
  assign m_tdata = {out_item.body_size, out_item.protocol_version,
                    out_item.command_code, out_item.packet_byte};
  assign m_tlast = out_item.end_of_packet;
  assign m_tuser = {out_item.framing_error, out_item.start_of_packet};

endmodule

`default_nettype wire

### rtl/length_prefixed_packet_deframer_top.sv
// ----------------------------------------------------------------------------
// length_prefixed_packet_deframer_top
// Splits a byte stream into packets of a 40-byte header plus a body.
//
// Input stream: one byte per item on s_tdata. Output stream: one item per
// accepted packet byte; tuser[0] marks the first header byte, tlast marks the
// last byte of header plus body and then tdata also carries the command id,
// version and body length (zero otherwise). If the body length is at or above
// the body_length_limit register (APB, address 0), header byte 39 instead
// yields a single item with tuser[1] set and all else zero, and every later
// byte is accepted and dropped until reset.
// Throughput: one byte per clock while the receiver keeps up. An accepted
// byte is written into the queue and then loaded into the output register
// before it shows on the master side. When the receiver stalls, the queue
// fills and s_tready drops once it is full; a held output item stays stable.
// Reset clears position, header fields, the halt flag and the queue, and sets
// the limit to 1024000.
// ----------------------------------------------------------------------------
`default_nettype none

module length_prefixed_packet_deframer_top #(
  parameter int unsigned QueueDepth = lppd_pkg::QueueDepth
) (
  input  wire          clk,
  input  wire          rst,
  // Input stream
  input  wire          s_tvalid,
  output logic         s_tready,
  input  wire  [7:0]   s_tdata,    // data_byte[7:0]
  // Output stream
  output logic         m_tvalid,
  input  wire          m_tready,
  output logic [71:0]  m_tdata,    // packet_byte[7:0], command_code[23:8],
                                   // protocol_version[39:24], body_size[71:40]
  output logic         m_tlast,    // end_of_packet
  output logic [1:0]   m_tuser,    // start_of_packet[0], framing_error[1]
  // Configuration
  input  wire          psel,
  input  wire          penable,
  input  wire          pwrite,
  input  wire  [2:0]   paddr,
  input  wire  [31:0]  pwdata,
  output logic [31:0]  prdata,
  output logic         pready
);

  logic [31:0]     body_length_limit;
  logic            push_valid;
  logic            push_ready;
  lppd_pkg::item_t push_item;
  logic            pop_valid;
  logic            pop_ready;
  lppd_pkg::item_t pop_item;

  // Configuration register
  assign pready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      body_length_limit <= lppd_pkg::LimitReset;
    end else if (psel && penable && pwrite && pready &&
                 (paddr[2] == lppd_pkg::RegBodyLimit)) begin
      body_length_limit <= pwdata;
    end
  end

  assign prdata = (paddr[2] == lppd_pkg::RegBodyLimit) ? body_length_limit : 32'd0;

  lppd_front u_front (
    .clk        (clk),
    .rst        (rst),
    .s_tvalid   (s_tvalid),
    .s_tready   (s_tready),
    .s_tdata    (s_tdata),
    .limit      (body_length_limit),
    .push_ready (push_ready),
    .push_valid (push_valid),
    .push_item  (push_item)
  );

  lppd_queue #(
    .Depth (QueueDepth)
  ) u_queue (
    .clk        (clk),
    .rst        (rst),
    .push_valid (push_valid),
    .push_ready (push_ready),
    .push_item  (push_item),
    .pop_valid  (pop_valid),
    .pop_ready  (pop_ready),
    .pop_item   (pop_item)
  );

  lppd_back u_back (
    .clk       (clk),
    .rst       (rst),
    .pop_valid (pop_valid),
    .pop_ready (pop_ready),
    .pop_item  (pop_item),
    .m_tvalid  (m_tvalid),
    .m_tready  (m_tready),
    .m_tdata   (m_tdata),
    .m_tlast   (m_tlast),
    .m_tuser   (m_tuser)
  );

endmodule

`default_nettype wire

### rtl/lppd_checker.sv
// ----------------------------------------------------------------------------
// lppd_checker
// Port-level checks on the deframer output stream.
// ----------------------------------------------------------------------------
`default_nettype none

module lppd_checker (
  input wire         clk,
  input wire         rst,
  input wire         m_tvalid,
  input wire         m_tready,
  input wire [71:0]  m_tdata,
  input wire         m_tlast,
  input wire [1:0]   m_tuser
);

  logic err_seen;

  // Remember that the error item went out
  always_ff @(posedge clk) begin
    if (rst) begin
      err_seen <= 1'b0;
    end else if (m_tvalid && m_tready && m_tuser[1]) begin
      err_seen <= 1'b1;
    end
  end

  // Hold a stalled item
  a_hold: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tlast)
      && $stable(m_tuser))
    else $error("output item changed while stalled");

  // Error item carries nothing else
  a_err_clean: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && m_tuser[1] |-> !m_tlast && !m_tuser[0] && (m_tdata == 72'd0))
    else $error("error item carries data or marks");

  // Header fields only with the end mark
  a_fields_eop: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tlast |-> (m_tdata[71:8] == 64'd0))
    else $error("header fields without end mark");

  // Nothing after the error item
  a_halt: assert property (@(posedge clk) disable iff (rst)
    err_seen |-> !m_tvalid)
    else $error("output after framing error");

endmodule

bind length_prefixed_packet_deframer_top lppd_checker u_lppd_checker (
  .clk      (clk),
  .rst      (rst),
  .m_tvalid (m_tvalid),
  .m_tready (m_tready),
  .m_tdata  (m_tdata),
  .m_tlast  (m_tlast),
  .m_tuser  (m_tuser)
);

`default_nettype wire

### bench/tb_top.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the length-prefixed packet deframer.
//
// A queue of stream bytes feeds a clocked driver on the input side. A clocked
// monitor runs every accepted byte through a local deframer model and checks
// each output item, field by field, against the oldest predicted item. The
// byte-limit register is moved between phases (reset value, 1, all ones,
// small random values) while the block is idle. The last phase hits the
// illegal-length case and then feeds bytes that must be dropped silently.
// Both sides idle and stall in random bursts, except in the final phase.
// ----------------------------------------------------------------------------
module tb_top;

  localparam int unsigned WatchdogLimit = 4000;
  localparam int unsigned DrainCycles   = 12;
  localparam int unsigned MaxReports    = 10;
  localparam logic [2:0]  LimitAddr     = 3'(lppd_pkg::RegBodyLimit) << 2;
  localparam logic [2:0]  UnmappedAddr  = 3'd4;   // past the register map
  localparam int          IdlePct [4]   = '{0, 10, 25, 50};

  // DUT inputs start at known values
  logic        clk      = 1'b0;
  logic        rst      = 1'b1;
  logic        s_tvalid = 1'b0;
  logic [7:0]  s_tdata  = 8'h00;
  logic        m_tready = 1'b0;
  logic        psel     = 1'b0;
  logic        penable  = 1'b0;
  logic        pwrite   = 1'b0;
  logic [2:0]  paddr    = 3'd0;
  logic [31:0] pwdata   = 32'd0;

  logic        s_tready;
  logic        m_tvalid;
  logic [71:0] m_tdata;
  logic        m_tlast;
  logic [1:0]  m_tuser;
  logic [31:0] prdata;
  logic        pready;

  // Stimulus and expectations
  logic [7:0]        stream_bytes [$];
  lppd_pkg::item_t   expected_items [$];

  // Local deframer state
  logic [32:0] hdr_pos       = '0;
  logic [31:0] len_field     = '0;
  logic [15:0] cmd_field     = '0;
  logic [15:0] ver_field     = '0;
  logic [31:0] limit_reg     = lppd_pkg::LimitReset;
  bit          stream_halted = 1'b0;

  // Bookkeeping
  int unsigned mismatch_count = 0;
  int unsigned bytes_fed      = 0;
  int unsigned items_checked  = 0;
  int unsigned packets_closed = 0;
  int unsigned stuck_cycles   = 0;
  int unsigned mix_timer      = 0;
  int          gap_pct        = 0;
  int          stall_pct      = 0;
  int          src_gap        = 0;
  int          sink_gap       = 0;
  bit          quiet          = 1'b0;

  always #5 clk = ~clk;

  length_prefixed_packet_deframer_top uut (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tlast  (m_tlast),
    .m_tuser  (m_tuser),
    .psel     (psel),
    .penable  (penable),
    .pwrite   (pwrite),
    .paddr    (paddr),
    .pwdata   (pwdata),
    .prdata   (prdata),
    .pready   (pready)
  );

  // Count a failure; print only the first few
  function automatic void report_fault(input string msg);
    mismatch_count++;
    if (mismatch_count <= MaxReports)
      $display("[%0t] %s", $time, msg);
  endfunction

  function automatic void check_field(input string field, input logic [31:0] want,
                                      input logic [31:0] seen);
    if (want !== seen)
      report_fault($sformatf("%s mismatch: expected 0x%0h, got 0x%0h", field, want, seen));
  endfunction

  // Advance the deframer by one byte and queue the item it yields, if any
  function automatic void deframe_byte(input logic [7:0] b);
    lppd_pkg::item_t res;
    logic [32:0]     last_pos;
    if (stream_halted)
      return;
    res = '0;
    case (hdr_pos)
      33'(lppd_pkg::PosVerLo): ver_field[7:0]   = b;
      33'(lppd_pkg::PosVerHi): ver_field[15:8]  = b;
      33'(lppd_pkg::PosCmdLo): cmd_field[7:0]   = b;
      33'(lppd_pkg::PosCmdHi): cmd_field[15:8]  = b;
      33'(lppd_pkg::PosLen0):  len_field[7:0]   = b;
      33'(lppd_pkg::PosLen1):  len_field[15:8]  = b;
      33'(lppd_pkg::PosLen2):  len_field[23:16] = b;
      33'(lppd_pkg::PosLen3):  len_field[31:24] = b;
      default: ;
    endcase
    // Illegal length: one error item on the last header byte, then halt
    if (hdr_pos == 33'(lppd_pkg::PosHdrLast) && len_field >= limit_reg) begin
      res.framing_error = 1'b1;
      stream_halted = 1'b1;
      expected_items.push_back(res);
      return;
    end
    last_pos = 33'(lppd_pkg::PosHdrLast) + 33'(len_field);
    res.packet_byte = b;
    res.start_of_packet = (hdr_pos == '0);
    if (hdr_pos >= 33'(lppd_pkg::PosHdrLast) && hdr_pos == last_pos) begin
      res.end_of_packet    = 1'b1;
      res.command_code     = cmd_field;
      res.protocol_version = ver_field;
      res.body_size        = len_field;
      hdr_pos = '0;
      packets_closed++;
    end else begin
      hdr_pos = hdr_pos + 33'd1;
    end
    expected_items.push_back(res);
  endfunction

  // Pick a header word: random half the time, else an extreme
  function automatic logic [15:0] pick_word();
    case ($urandom_range(0, 3))
      0:       return 16'h0000;
      1:       return 16'hFFFF;
      default: return 16'($urandom);
    endcase
  endfunction

  // Queue one packet; body bytes are random and only queued when asked
  task automatic queue_packet(input logic [15:0] ver, input logic [15:0] cmd,
                              input logic [31:0] len, input bit with_body);
    logic [7:0] hdr [8];
    hdr = '{ver[7:0], ver[15:8], cmd[7:0], cmd[15:8],
            len[7:0], len[15:8], len[23:16], len[31:24]};
    foreach (hdr[i])
      stream_bytes.push_back(hdr[i]);
    repeat (lppd_pkg::SessionBytes)
      stream_bytes.push_back(8'($urandom));
    if (with_body)
      repeat (len)
        stream_bytes.push_back(8'($urandom));
  endtask

  task automatic queue_random_packets(input int budget, input int max_len);
    int len;
    while (budget > 0) begin
      len = $urandom_range(0, max_len);
      queue_packet(pick_word(), pick_word(), 32'(len), 1'b1);
      budget -= lppd_pkg::HeaderBytes + len;
    end
  endtask

  // Wait until all bytes are in and all items out, then let the pipe settle
  task automatic wait_idle();
    while (stream_bytes.size() != 0 || s_tvalid || expected_items.size() != 0)
      @(negedge clk);
    repeat (DrainCycles) @(posedge clk);
  endtask

  task automatic apb_write(input logic [2:0] addr, input logic [31:0] data);
    @(posedge clk);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= addr;
    pwdata  <= data;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
  endtask

  // Read the limit back and compare with the local copy
  task automatic check_limit_readback();
    logic [31:0] rd;
    @(posedge clk);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    paddr   <= LimitAddr;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    rd = prdata;
    psel    <= 1'b0;
    penable <= 1'b0;
    check_field("body_length_limit readback", limit_reg, rd);
  endtask

  task automatic set_limit(input logic [31:0] value);
    wait_idle();
    apb_write(LimitAddr, value);
    limit_reg = value;
    check_limit_readback();
  endtask

  // Input driver: hold a byte until taken, insert idle bursts
  always @(posedge clk) begin
    if (rst) begin
      s_tvalid <= 1'b0;
      src_gap = 0;
    end else if (!s_tvalid || s_tready) begin
      if (src_gap > 0) begin
        src_gap--;
        s_tvalid <= 1'b0;
      end else if (!quiet && gap_pct != 0 && $urandom_range(0, 99) < gap_pct) begin
        src_gap = $urandom_range(0, 5);
        s_tvalid <= 1'b0;
      end else if (stream_bytes.size() != 0) begin
        s_tdata  <= stream_bytes.pop_front();
        s_tvalid <= 1'b1;
      end else begin
        s_tvalid <= 1'b0;
      end
    end
  end

  // Output side: stall in bursts
  always @(posedge clk) begin
    if (rst) begin
      m_tready <= 1'b0;
      sink_gap = 0;
    end else if (sink_gap > 0) begin
      sink_gap--;
      m_tready <= 1'b0;
    end else if (!quiet && stall_pct != 0 && $urandom_range(0, 99) < stall_pct) begin
      sink_gap = $urandom_range(0, 5);
      m_tready <= 1'b0;
    end else begin
      m_tready <= 1'b1;
    end
  end

  // Re-pick idle and stall rates now and then, zero included
  always @(posedge clk) begin
    mix_timer <= mix_timer + 1;
    if (mix_timer % 160 == 0) begin
      gap_pct   <= IdlePct[$urandom_range(0, 3)];
      stall_pct <= IdlePct[$urandom_range(0, 3)];
    end
  end

  // Monitor: check taken items first, then predict from the taken byte
  always @(posedge clk) begin
    lppd_pkg::item_t want;
    if (!rst && m_tvalid && m_tready) begin
      items_checked++;
      if (expected_items.size() == 0) begin
        report_fault($sformatf("unexpected item: tdata 0x%0h tlast %0b tuser 0x%0h",
                               m_tdata, m_tlast, m_tuser));
      end else begin
        want = expected_items.pop_front();
        check_field("packet_byte",      want.packet_byte,      m_tdata[7:0]);
        check_field("command_code",     want.command_code,     m_tdata[23:8]);
        check_field("protocol_version", want.protocol_version, m_tdata[39:24]);
        check_field("body_size",        want.body_size,        m_tdata[71:40]);
        check_field("end_of_packet",    want.end_of_packet,    m_tlast);
        check_field("start_of_packet",  want.start_of_packet,  m_tuser[0]);
        check_field("framing_error",    want.framing_error,    m_tuser[1]);
      end
    end
    if (!rst && s_tvalid && s_tready) begin
      bytes_fed++;
      deframe_byte(s_tdata);
    end
  end

  // Watchdog: give up after a long stretch with no progress
  always @(posedge clk) begin
    if (rst || psel || (s_tvalid && s_tready) || (m_tvalid && m_tready))
      stuck_cycles <= 0;
    else
      stuck_cycles <= stuck_cycles + 1;
    if (stuck_cycles >= WatchdogLimit) begin
      $display("[%0t] watchdog: no progress for %0d cycles", $time, stuck_cycles);
      $display("Some tests failed");
      $finish;
    end
  end

  initial begin
    logic [31:0] limit_pick;
    repeat (10) @(posedge clk);
    rst <= 1'b0;

    // Directed: header word extremes, empty body, one-byte body, body byte extremes
    queue_packet(16'hFFFF, 16'h0000, 32'd0, 1'b1);
    queue_packet(16'h0000, 16'hFFFF, 32'd1, 1'b1);
    stream_bytes[stream_bytes.size() - 1] = 8'hFF;
    queue_packet(16'h1234, 16'hA55A, 32'd3, 1'b1);
    stream_bytes[stream_bytes.size() - 3] = 8'h00;
    stream_bytes[stream_bytes.size() - 2] = 8'h80;
    stream_bytes[stream_bytes.size() - 1] = 8'h7F;

    // Lowest limit: only empty bodies are legal
    set_limit(32'd1);
    queue_random_packets(160, 0);

    // Highest limit, one long body
    set_limit(32'hFFFF_FFFF);
    queue_packet(pick_word(), pick_word(), 32'd200, 1'b1);
    queue_random_packets(150, 48);

    // A write outside the map must leave the limit alone
    wait_idle();
    apb_write(UnmappedAddr, $urandom);
    check_limit_readback();

    // Small random limits, each starting with a body one below the limit
    repeat (2) begin
      limit_pick = $urandom_range(2, 64);
      set_limit(limit_pick);
      queue_packet(pick_word(), pick_word(), limit_pick - 1, 1'b1);
      queue_random_packets(150, limit_pick - 1);
    end

    set_limit(lppd_pkg::LimitReset);
    queue_random_packets(100, 40);

    // Final phase without idling: legal traffic, a length equal to the
    // limit, then bytes that must be dropped
    set_limit(32'd20);
    quiet <= 1'b1;
    queue_packet(pick_word(), pick_word(), 32'd19, 1'b1);
    queue_random_packets(150, 19);
    queue_packet(pick_word(), pick_word(), 32'd20, 1'b0);
    repeat (40)
      stream_bytes.push_back(8'($urandom));
    wait_idle();

    if (!stream_halted)
      report_fault("illegal length was never reached");
    $display("Fed %0d bytes, checked %0d output items over %0d complete packets,",
             bytes_fed, items_checked, packets_closed);
    $display("with limits from 1 to all ones and a final halt on an illegal length.");
    if (mismatch_count == 0 && expected_items.size() == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule
